### hw/rtl/tecc_pkg.sv
// tecc_pkg: shared types, register indexes, tag codes and helper functions
// for the track endpoint containment tagger. No dependencies.
`timescale 1ns / 1ps

package tecc_pkg;

  // field and datapath widths
  localparam int unsigned CoordW   = 24;  // input coordinate, two's complement
  localparam int unsigned CmpW     = 26;  // signed width that holds every bound exactly
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 23;
  localparam int unsigned LenW     = 23;
  localparam int unsigned HalfHW   = 23;
  localparam int unsigned HalfWW   = 22;
  localparam int unsigned MarginW  = 23;

  // register reset values, 0.1 mm units
  localparam logic [LenW-1:0]    LenZRst    = LenW'(103700);
  localparam logic [HalfHW-1:0]  HalfHYRst  = HalfHW'(11650);
  localparam logic [HalfWW-1:0]  HalfWXRst  = HalfWW'(12800);
  localparam logic [MarginW-1:0] MarginZRst = '0;
  localparam logic [MarginW-1:0] MarginYRst = '0;
  localparam logic [MarginW-1:0] MarginXRst = '0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOX_LENGTH_Z      = 3'd0,
    REG_BOX_HALF_HEIGHT_Y = 3'd1,
    REG_BOX_HALF_WIDTH_X  = 3'd2,
    REG_MARGIN_Z          = 3'd3,
    REG_MARGIN_Y          = 3'd4,
    REG_MARGIN_X          = 3'd5
  } cfg_reg_e;

  typedef enum logic [1:0] {
    AXIS_NONE = 2'd0,
    AXIS_Z    = 2'd1,
    AXIS_Y    = 2'd2,
    AXIS_X    = 2'd3
  } axis_e;

  typedef enum logic [3:0] {
    TAG_NONE           = 4'd0,
    TAG_Z              = 4'd1,
    TAG_Y              = 4'd2,
    TAG_X              = 4'd3,
    TAG_ZZ             = 4'd4,
    TAG_YZ             = 4'd5,
    TAG_XZ             = 4'd6,
    TAG_YY             = 4'd7,
    TAG_XY             = 4'd8,
    TAG_XX             = 4'd9,
    TAG_DRIFT_PARTIAL  = 4'd10,
    TAG_DRIFT_COMPLETE = 4'd11
  } tag_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CmpW-1:0]   cmp_t;

  // shrunk box bounds, all at comparison width
  typedef struct packed {
    cmp_t z_lo;   // margin_z
    cmp_t z_hi;   // length - margin_z
    cmp_t y_lo;   // margin_y - half height
    cmp_t y_hi;   // half height - margin_y
    cmp_t x_lo;   // margin_x
    cmp_t x_hi;   // 2*half width - margin_x
    cmp_t x_top;  // 2*half width, end of drift range
  } bounds_t;

  // raw comparison flags of one point
  typedef struct packed {
    logic z_lo;     // z < margin_z
    logic z_hi;     // z > length - margin_z
    logic y_lo;     // y below lower y bound
    logic y_hi;     // y above upper y bound
    logic x_pos;    // x > 0
    logic x_ltm;    // x < margin_x
    logic x_lttop;  // x < 2w
    logic x_gthi;   // x > 2w - margin_x
    logic x_neg;    // x < 0
    logic x_gttop;  // x > 2w
  } pt_cmp_t;

  // per point summary
  typedef struct packed {
    axis_e fail;
    logic  in_box;
    logic  drift_out;
  } pt_res_t;

  function automatic bounds_t make_bounds(
    input logic [LenW-1:0]    len,
    input logic [HalfHW-1:0]  hh,
    input logic [HalfWW-1:0]  hw,
    input logic [MarginW-1:0] mz,
    input logic [MarginW-1:0] my,
    input logic [MarginW-1:0] mx
  );
    bounds_t b;
    cmp_t    len_e, hh_e, w2_e, mz_e, my_e, mx_e;
    len_e = {{(CmpW-LenW){1'b0}}, len};
    hh_e  = {{(CmpW-HalfHW){1'b0}}, hh};
    w2_e  = {{(CmpW-HalfWW-1){1'b0}}, hw, 1'b0};
    mz_e  = {{(CmpW-MarginW){1'b0}}, mz};
    my_e  = {{(CmpW-MarginW){1'b0}}, my};
    mx_e  = {{(CmpW-MarginW){1'b0}}, mx};
    b.z_lo  = mz_e;
    b.z_hi  = len_e - mz_e;
    b.y_lo  = my_e - hh_e;
    b.y_hi  = hh_e - my_e;
    b.x_lo  = mx_e;
    b.x_hi  = w2_e - mx_e;
    b.x_top = w2_e;
    return b;
  endfunction

  // first failing axis (z, then y, then x), containment and drift flag
  function automatic pt_res_t encode_point(input pt_cmp_t c);
    pt_res_t r;
    logic    zf, yf, xf;
    zf = c.z_lo | c.z_hi;
    yf = c.y_lo | c.y_hi;
    xf = (c.x_pos & c.x_ltm) | (c.x_lttop & c.x_gthi);
    priority if (zf) begin
      r.fail = AXIS_Z;
    end else if (yf) begin
      r.fail = AXIS_Y;
    end else if (xf) begin
      r.fail = AXIS_X;
    end else begin
      r.fail = AXIS_NONE;
    end
    r.in_box    = ~zf & ~yf & ~c.x_ltm & ~c.x_gthi;
    r.drift_out = c.x_neg | c.x_gttop;
    return r;
  endfunction

  // combine the start point's failing axis with the end point's failing axis
  function automatic tag_e pair_tag(input axis_e s, input axis_e e);
    tag_e t;
    t = TAG_NONE;
    unique case (e)
      AXIS_NONE: begin
        unique case (s)
          AXIS_NONE: t = TAG_NONE;
          AXIS_Z:    t = TAG_Z;
          AXIS_Y:    t = TAG_Y;
          AXIS_X:    t = TAG_X;
        endcase
      end
      AXIS_Z: begin
        unique case (s)
          AXIS_NONE: t = TAG_Z;
          AXIS_Z:    t = TAG_ZZ;
          AXIS_Y:    t = TAG_YZ;
          AXIS_X:    t = TAG_XZ;
        endcase
      end
      AXIS_Y: begin
        unique case (s)
          AXIS_NONE: t = TAG_Y;
          AXIS_Z:    t = TAG_YZ;
          AXIS_Y:    t = TAG_YY;
          AXIS_X:    t = TAG_XY;
        endcase
      end
      AXIS_X: begin
        unique case (s)
          AXIS_NONE: t = TAG_X;
          AXIS_Z:    t = TAG_XZ;
          AXIS_Y:    t = TAG_XY;
          AXIS_X:    t = TAG_XX;
        endcase
      end
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/tecc_cfg.sv
// tecc_cfg: configuration register file and registered shrunk box bounds.
// Depends on tecc_pkg.
`timescale 1ns / 1ps

module tecc_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tecc_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [tecc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output tecc_pkg::bounds_t               bounds_o
);
  import tecc_pkg::*;

  localparam bounds_t BoundsRst = make_bounds(LenZRst, HalfHYRst, HalfWXRst,
                                              MarginZRst, MarginYRst, MarginXRst);

  logic [LenW-1:0]    len_q;
  logic [HalfHW-1:0]  hh_q;
  logic [HalfWW-1:0]  hw_q;
  logic [MarginW-1:0] mz_q, my_q, mx_q;
  bounds_t            bounds_d, bounds_q;

  // register writes, indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LenZRst;
      hh_q  <= HalfHYRst;
      hw_q  <= HalfWXRst;
      mz_q  <= MarginZRst;
      my_q  <= MarginYRst;
      mx_q  <= MarginXRst;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_BOX_LENGTH_Z:      len_q <= cfg_wdata_i[LenW-1:0];
        REG_BOX_HALF_HEIGHT_Y: hh_q  <= cfg_wdata_i[HalfHW-1:0];
        REG_BOX_HALF_WIDTH_X:  hw_q  <= cfg_wdata_i[HalfWW-1:0];
        REG_MARGIN_Z:          mz_q  <= cfg_wdata_i[MarginW-1:0];
        REG_MARGIN_Y:          my_q  <= cfg_wdata_i[MarginW-1:0];
        REG_MARGIN_X:          mx_q  <= cfg_wdata_i[MarginW-1:0];
        default: ;
      endcase
    end
  end

  // bounds are subtracted once and held, off the compare path
  assign bounds_d = make_bounds(len_q, hh_q, hw_q, mz_q, my_q, mx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounds_q <= BoundsRst;
    end else begin
      bounds_q <= bounds_d;
    end
  end

  assign bounds_o = bounds_q;

endmodule

### hw/rtl/tecc_point.sv
// tecc_point: compares one point against the shrunk box bounds.
// Depends on tecc_pkg.
`timescale 1ns / 1ps

module tecc_point (
  input  tecc_pkg::coord_t   x_i,
  input  tecc_pkg::coord_t   y_i,
  input  tecc_pkg::coord_t   z_i,
  input  tecc_pkg::bounds_t  bounds_i,
  output tecc_pkg::pt_cmp_t  cmp_o
);
  import tecc_pkg::*;

  cmp_t x_e, y_e, z_e;

  // sign extend to the bound width
  assign x_e = {{(CmpW-CoordW){x_i[CoordW-1]}}, x_i};
  assign y_e = {{(CmpW-CoordW){y_i[CoordW-1]}}, y_i};
  assign z_e = {{(CmpW-CoordW){z_i[CoordW-1]}}, z_i};

  // face compares
  always_comb begin
    cmp_o.z_lo    = $signed(z_e) < $signed(bounds_i.z_lo);
    cmp_o.z_hi    = $signed(z_e) > $signed(bounds_i.z_hi);
    cmp_o.y_lo    = $signed(y_e) < $signed(bounds_i.y_lo);
    cmp_o.y_hi    = $signed(y_e) > $signed(bounds_i.y_hi);
    cmp_o.x_pos   = ~x_i[CoordW-1] & (|x_i);
    cmp_o.x_ltm   = $signed(x_e) < $signed(bounds_i.x_lo);
    cmp_o.x_lttop = $signed(x_e) < $signed(bounds_i.x_top);
    cmp_o.x_gthi  = $signed(x_e) > $signed(bounds_i.x_hi);
    cmp_o.x_neg   = x_i[CoordW-1];
    cmp_o.x_gttop = $signed(x_e) > $signed(bounds_i.x_top);
  end

endmodule

### hw/rtl/track_endpoint_containment_tagger.sv
// Track endpoint containment tagger, four register stages:
// input capture, face compares, per point encode, tag combine.
// Throughput: one track per cycle; busy_o stays low, the receiver cannot stall.
// Reset: asynchronous, active low; clears the valid bits and loads the
// register reset values.
`timescale 1ns / 1ps

module track_endpoint_containment_tagger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  tecc_pkg::coord_t               start_x_i,
  input  tecc_pkg::coord_t               start_y_i,
  input  tecc_pkg::coord_t               start_z_i,
  input  tecc_pkg::coord_t               end_x_i,
  input  tecc_pkg::coord_t               end_y_i,
  input  tecc_pkg::coord_t               end_z_i,
  input  logic                           cfg_we_i,
  input  logic [tecc_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  logic [tecc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output logic                           done_o,
  output logic                           contained_o,
  output logic [3:0]                     tag_code_o
);
  import tecc_pkg::*;

  bounds_t bounds;
  logic    take;

  logic    v0_q, v1_q, v2_q, done_q;
  coord_t  sx_q, sy_q, sz_q, ex_q, ey_q, ez_q;
  pt_cmp_t scmp, ecmp, scmp_q, ecmp_q;
  pt_res_t sres_d, eres_d, sres_q, eres_q;
  logic    contained_d, contained_q;
  tag_e    tag_d, tag_q;

  assign busy_o = 1'b0;
  assign take   = start_i & ~busy_o;

  tecc_cfg u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .bounds_o (bounds)
  );

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q   <= 1'b0;
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v0_q   <= take;
      v1_q   <= v0_q;
      v2_q   <= v1_q;
      done_q <= v2_q;
    end
  end

  // stage 0: capture the input word
  always_ff @(posedge clk_i) begin
    if (take) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      sz_q <= start_z_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
      ez_q <= end_z_i;
    end
  end

  // stage 1: face compares for both points
  tecc_point u_start (
    .x_i      (sx_q),
    .y_i      (sy_q),
    .z_i      (sz_q),
    .bounds_i (bounds),
    .cmp_o    (scmp)
  );

  tecc_point u_end (
    .x_i      (ex_q),
    .y_i      (ey_q),
    .z_i      (ez_q),
    .bounds_i (bounds),
    .cmp_o    (ecmp)
  );

  always_ff @(posedge clk_i) begin
    if (v0_q) begin
      scmp_q <= scmp;
      ecmp_q <= ecmp;
    end
  end

  // stage 2: first failing axis and containment per point
  assign sres_d = encode_point(scmp_q);
  assign eres_d = encode_point(ecmp_q);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sres_q <= sres_d;
      eres_q <= eres_d;
    end
  end

  // stage 3: pair code, then the drift range override
  always_comb begin
    tag_d = pair_tag(sres_q.fail, eres_q.fail);
    if (sres_q.drift_out) begin
      tag_d = TAG_DRIFT_PARTIAL;
    end
    if (eres_q.drift_out) begin
      tag_d = (tag_d == TAG_DRIFT_PARTIAL) ? TAG_DRIFT_COMPLETE : TAG_DRIFT_PARTIAL;
    end
    contained_d = sres_q.in_box & eres_q.in_box;
  end

  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      tag_q       <= tag_d;
      contained_q <= contained_d;
    end
  end

  assign done_o      = done_q;
  assign contained_o = contained_q;
  assign tag_code_o  = tag_q;

  // every accepted word comes out with a done_o strobe
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ##4 done_o)
    else $error("accepted word produced no result");

  // no result without a matching accepted word
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(take, 4))
    else $error("result without accepted word");

  // a contained track carries no face or drift tag
  a_contained_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && contained_o) |-> (tag_code_o == TAG_NONE))
    else $error("contained track with nonzero tag");

  // tag code stays within the defined codes
  a_tag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (tag_code_o <= TAG_DRIFT_COMPLETE))
    else $error("tag code out of range");

endmodule
